>>> design/coap_message_deframer_assert.svh
`ifndef COAP_MESSAGE_DEFRAMER_ASSERT_SVH
`define COAP_MESSAGE_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked on clk while out of reset
`define COAP_DFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define COAP_DFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/coap_dfr_pkg.sv
package coap_dfr_pkg;

    typedef enum logic [3:0] {
        PH_H0,
        PH_H1,
        PH_H2,
        PH_H3,
        PH_TOKEN,
        PH_OPT,
        PH_DEXT_A,
        PH_DEXT_B,
        PH_LEXT_A,
        PH_LEXT_B,
        PH_VALUE,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HDR_BYTE,
        KIND_HDR_DONE,
        KIND_TOKEN,
        KIND_OPT_DONE,
        KIND_OPT_VALUE,
        KIND_PAYLOAD,
        KIND_ERROR,
        KIND_MARKER
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_VERSION,
        ERR_SHORT,
        ERR_NIBBLE15,
        ERR_UNKNOWN_OPT,
        ERR_NO_MARKER
    } err_t;

    typedef enum logic [1:0] {
        EXT_NONE,
        EXT_ONE,
        EXT_TWO
    } ext_mode_t;

    localparam logic [1:0]  COAP_VERSION  = 2'b01;
    localparam logic [7:0]  PAYLOAD_MARK  = 8'hFF;
    localparam logic [3:0]  NIB_EXT_ONE   = 4'hD;
    localparam logic [3:0]  NIB_EXT_TWO   = 4'hE;
    localparam logic [3:0]  NIB_RESERVED  = 4'hF;
    localparam logic [16:0] EXT_ONE_BIAS  = 17'h0000D;
    localparam logic [16:0] EXT_TWO_BIAS  = 17'h0010D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        kind_t       element_kind;
        logic [1:0]  message_type;
        logic [3:0]  token_length;
        logic [7:0]  code_value;
        logic [15:0] msg_ident;
        logic [15:0] option_number;
        logic [16:0] option_length;
        logic [7:0]  out_byte;
        err_t        error_code;
        logic        message_end;
    } result_t;

    function automatic ext_mode_t ext_mode(input logic [3:0] nib);
        ext_mode_t m;
        m = EXT_NONE;
        if (nib == NIB_EXT_ONE)
        begin
            m = EXT_ONE;
        end
        else if (nib == NIB_EXT_TWO)
        begin
            m = EXT_TWO;
        end
        return m;
    endfunction

    // supported option numbers
    function automatic logic option_known(input logic [17:0] num);
        logic ok;
        case (num) inside
            18'd1, 18'd3, 18'd4, 18'd5, 18'd7, 18'd8, 18'd11, 18'd12,
            18'd15, 18'd17, 18'd20, 18'd35, 18'd39, 18'd60: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

>>> design/coap_dfr_if.sv
interface coap_dfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface coap_dfr_elem_if;
    logic        valid;
    logic        ready;
    logic [2:0]  element_kind;
    logic [1:0]  message_type;
    logic [3:0]  token_length;
    logic [7:0]  code_value;
    logic [15:0] msg_ident;
    logic [15:0] option_number;
    logic [16:0] option_length;
    logic [7:0]  out_byte;
    logic [2:0]  error_code;
    logic        message_end;

    modport source (
        output valid, output element_kind, output message_type, output token_length,
        output code_value, output msg_ident, output option_number,
        output option_length, output out_byte, output error_code, output message_end,
        input ready
    );
    modport sink (
        input valid, input element_kind, input message_type, input token_length,
        input code_value, input msg_ident, input option_number,
        input option_length, input out_byte, input error_code, input message_end,
        output ready
    );
endinterface

>>> design/coap_dfr_in_reg.sv
module coap_dfr_in_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    coap_dfr_byte_if.sink         byte_ch,
    input  logic                  advance,
    output logic                  item_valid,
    output coap_dfr_pkg::in_item_t item
);
    import coap_dfr_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // refill in the same cycle the held byte moves on
    assign byte_ch.ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            valid_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.ready && byte_ch.valid)
        begin
            item_reg.data_byte <= byte_ch.data_byte;
            item_reg.last_byte <= byte_ch.last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> design/coap_dfr_core.sv
`include "coap_message_deframer_assert.svh"

module coap_dfr_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  coap_dfr_pkg::in_item_t item,
    output coap_dfr_pkg::result_t  result
);
    import coap_dfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] header_reg, header_next;
    logic [16:0] left_reg, left_next;
    logic [15:0] prev_reg, prev_next;
    logic [16:0] pdelta_reg, pdelta_next;
    logic [16:0] plen_reg, plen_next;
    ext_mode_t   dmode_reg, dmode_next;
    ext_mode_t   lmode_reg, lmode_next;
    err_t        err_code_reg, err_code_next;
    logic        err_latched_reg, err_latched_next;

    logic [7:0]  b;
    logic [3:0]  dn;
    logic [3:0]  ln;
    logic [16:0] left_dec;
    logic [17:0] num_sum;
    logic        want_after_delta;
    logic        want_finish;
    kind_t       kind;
    logic [15:0] onum;
    logic [16:0] olen;
    logic [7:0]  ob;

    assign b        = item.data_byte;
    assign dn       = b[7:4];
    assign ln       = b[3:0];
    assign left_dec = left_reg - 17'd1;
    assign num_sum  = {2'b00, prev_reg} + {1'b0, pdelta_next};

    always_comb
    begin
        phase_next       = phase_reg;
        header_next      = header_reg;
        left_next        = left_reg;
        prev_next        = prev_reg;
        pdelta_next      = pdelta_reg;
        plen_next        = plen_reg;
        dmode_next       = dmode_reg;
        lmode_next       = lmode_reg;
        err_code_next    = err_code_reg;
        err_latched_next = err_latched_reg;
        want_after_delta = 1'b0;
        want_finish      = 1'b0;
        kind             = KIND_HDR_BYTE;
        onum             = '0;
        olen             = '0;
        ob               = '0;

        if (err_latched_reg)
        begin
            kind = KIND_ERROR;
        end
        else
        begin
            unique case (phase_reg)
                PH_H0:
                begin
                    header_next[31:24] = b;
                    if (b[7:6] != COAP_VERSION)
                    begin
                        err_latched_next = 1'b1;
                        err_code_next    = ERR_VERSION;
                        kind             = KIND_ERROR;
                    end
                    else
                    begin
                        phase_next = PH_H1;
                    end
                end
                PH_H1:
                begin
                    header_next[23:16] = b;
                    phase_next         = PH_H2;
                end
                PH_H2:
                begin
                    header_next[15:8] = b;
                    phase_next        = PH_H3;
                end
                PH_H3:
                begin
                    header_next[7:0] = b;
                    kind             = KIND_HDR_DONE;
                    if (header_reg[27:24] != 4'd0)
                    begin
                        left_next  = {13'd0, header_reg[27:24]};
                        phase_next = PH_TOKEN;
                    end
                    else
                    begin
                        phase_next = PH_OPT;
                    end
                end
                PH_TOKEN:
                begin
                    kind      = KIND_TOKEN;
                    ob        = b;
                    left_next = left_dec;
                    if (left_dec == 17'd0)
                    begin
                        phase_next = PH_OPT;
                    end
                end
                PH_OPT:
                begin
                    if (b == PAYLOAD_MARK)
                    begin
                        kind       = KIND_MARKER;
                        phase_next = PH_PAYLOAD;
                    end
                    else if (dn == NIB_RESERVED || ln == NIB_RESERVED)
                    begin
                        err_latched_next = 1'b1;
                        err_code_next    = ERR_NIBBLE15;
                        kind             = KIND_ERROR;
                    end
                    else
                    begin
                        pdelta_next = (dn < NIB_EXT_ONE) ? {13'd0, dn} : 17'd0;
                        plen_next   = (ln < NIB_EXT_ONE) ? {13'd0, ln} : 17'd0;
                        dmode_next  = ext_mode(dn);
                        lmode_next  = ext_mode(ln);
                        if (dmode_next != EXT_NONE)
                        begin
                            phase_next = PH_DEXT_A;
                        end
                        else
                        begin
                            want_after_delta = 1'b1;
                        end
                    end
                end
                PH_DEXT_A:
                begin
                    if (dmode_reg == EXT_ONE)
                    begin
                        pdelta_next      = {9'd0, b} + EXT_ONE_BIAS;
                        want_after_delta = 1'b1;
                    end
                    else
                    begin
                        pdelta_next = {1'b0, b, 8'd0};
                        phase_next  = PH_DEXT_B;
                    end
                end
                PH_DEXT_B:
                begin
                    pdelta_next      = {1'b0, pdelta_reg[15:8], b} + EXT_TWO_BIAS;
                    want_after_delta = 1'b1;
                end
                PH_LEXT_A:
                begin
                    if (lmode_reg == EXT_ONE)
                    begin
                        plen_next   = {9'd0, b} + EXT_ONE_BIAS;
                        want_finish = 1'b1;
                    end
                    else
                    begin
                        plen_next  = {1'b0, b, 8'd0};
                        phase_next = PH_LEXT_B;
                    end
                end
                PH_LEXT_B:
                begin
                    plen_next   = {1'b0, plen_reg[15:8], b} + EXT_TWO_BIAS;
                    want_finish = 1'b1;
                end
                PH_VALUE:
                begin
                    kind      = KIND_OPT_VALUE;
                    ob        = b;
                    onum      = prev_reg;
                    olen      = plen_reg;
                    left_next = left_dec;
                    if (left_dec == 17'd0)
                    begin
                        phase_next = PH_OPT;
                    end
                end
                PH_PAYLOAD:
                begin
                    kind = KIND_PAYLOAD;
                    ob   = b;
                end
                default:
                begin
                    err_latched_next = 1'b1;
                    err_code_next    = ERR_SHORT;
                    kind             = KIND_ERROR;
                end
            endcase

            // delta settled: length extension bytes still to come, or done
            if (want_after_delta)
            begin
                if (lmode_next != EXT_NONE)
                begin
                    phase_next = PH_LEXT_A;
                end
                else
                begin
                    want_finish = 1'b1;
                end
            end

            if (want_finish)
            begin
                if (!option_known(num_sum))
                begin
                    err_latched_next = 1'b1;
                    err_code_next    = ERR_UNKNOWN_OPT;
                    kind             = KIND_ERROR;
                end
                else
                begin
                    prev_next = num_sum[15:0];
                    onum      = num_sum[15:0];
                    olen      = plen_next;
                    kind      = KIND_OPT_DONE;
                    if (plen_next != 17'd0)
                    begin
                        left_next  = plen_next;
                        phase_next = PH_VALUE;
                    end
                    else
                    begin
                        phase_next = PH_OPT;
                    end
                end
            end

            // datagram ended before the payload
            if (item.last_byte && !err_latched_next && phase_next != PH_PAYLOAD)
            begin
                err_latched_next = 1'b1;
                err_code_next    = (phase_next == PH_OPT) ? ERR_NO_MARKER : ERR_SHORT;
                kind             = KIND_ERROR;
            end
        end

        result.element_kind  = kind;
        result.message_type  = header_next[29:28];
        result.token_length  = header_next[27:24];
        result.code_value    = header_next[23:16];
        result.msg_ident     = header_next[15:0];
        result.option_number = onum;
        result.option_length = olen;
        result.out_byte      = ob;
        result.error_code    = ERR_NONE;
        result.message_end   = item.last_byte;
        if (kind == KIND_ERROR)
        begin
            result.error_code    = err_code_next;
            result.option_number = '0;
            result.option_length = '0;
            result.out_byte      = '0;
        end

        // next datagram starts from scratch
        if (item.last_byte)
        begin
            phase_next       = PH_H0;
            header_next      = '0;
            left_next        = '0;
            prev_next        = '0;
            pdelta_next      = '0;
            plen_next        = '0;
            dmode_next       = EXT_NONE;
            lmode_next       = EXT_NONE;
            err_code_next    = ERR_NONE;
            err_latched_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_H0;
            header_reg      <= '0;
            left_reg        <= '0;
            prev_reg        <= '0;
            pdelta_reg      <= '0;
            plen_reg        <= '0;
            dmode_reg       <= EXT_NONE;
            lmode_reg       <= EXT_NONE;
            err_code_reg    <= ERR_NONE;
            err_latched_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            header_reg      <= header_next;
            left_reg        <= left_next;
            prev_reg        <= prev_next;
            pdelta_reg      <= pdelta_next;
            plen_reg        <= plen_next;
            dmode_reg       <= dmode_next;
            lmode_reg       <= lmode_next;
            err_code_reg    <= err_code_next;
            err_latched_reg <= err_latched_next;
        end
    end

    `COAP_DFR_ASSERT_NOW(a_err_has_code,
        step_en && result.element_kind == KIND_ERROR,
        result.error_code != ERR_NONE,
        "error result without an error code")
    `COAP_DFR_ASSERT_NOW(a_code_only_on_err,
        step_en && result.element_kind != KIND_ERROR,
        result.error_code == ERR_NONE,
        "error code on a non-error result")
    `COAP_DFR_ASSERT_NEXT(a_restart_after_last,
        step_en && item.last_byte,
        phase_reg == PH_H0 && !err_latched_reg && header_reg == 32'd0,
        "parser not back at the header after the final byte")
    `COAP_DFR_ASSERT_NEXT(a_error_sticks,
        err_latched_reg && !(step_en && item.last_byte),
        err_latched_reg && err_code_reg == $past(err_code_reg),
        "latched error dropped before the end of the datagram")

endmodule

>>> design/coap_dfr_out_reg.sv
module coap_dfr_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  coap_dfr_pkg::result_t result_in,
    output logic                  can_load,
    coap_dfr_elem_if.source       elem_ch
);
    import coap_dfr_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // slot is free when empty or being drained this cycle
    assign can_load = !valid_reg || elem_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign elem_ch.valid         = valid_reg;
    assign elem_ch.element_kind  = result_reg.element_kind;
    assign elem_ch.message_type  = result_reg.message_type;
    assign elem_ch.token_length  = result_reg.token_length;
    assign elem_ch.code_value    = result_reg.code_value;
    assign elem_ch.msg_ident     = result_reg.msg_ident;
    assign elem_ch.option_number = result_reg.option_number;
    assign elem_ch.option_length = result_reg.option_length;
    assign elem_ch.out_byte      = result_reg.out_byte;
    assign elem_ch.error_code    = result_reg.error_code;
    assign elem_ch.message_end   = result_reg.message_end;

endmodule

>>> design/coap_message_deframer.sv
// CoAP datagram deframer, one byte in and one tagged element out per transaction.
// byte_ch (sink): data_byte plus last_byte, which marks the final byte of a datagram.
// elem_ch (source): element kind, header fields seen so far, current option number
// and length, the passed-through byte, an error code and message_end.
// Each byte is held in the input register; its element is then registered in the result
// register, which drives elem_ch.
// Throughput: one byte per cycle, sustained while elem_ch is ready; the per-byte parser
// state register updates once per byte, so the parser state loop sets the rate.
// When elem_ch stalls, the held result stays put and the input register still takes
// one more byte; byte_ch.ready drops only when both registers are full.
// Errors latch: every later byte of the same datagram reports the same error code.
// After the byte with last_byte set, the parser restarts for the next datagram.
// Reset: rst_n is asynchronous and active low; it empties both registers and puts
// the parser at the first header byte. No clearing pass, bytes are taken right away.
module coap_message_deframer (
    input  logic            clk,
    input  logic            rst_n,
    coap_dfr_byte_if.sink   byte_ch,
    coap_dfr_elem_if.source elem_ch
);
    import coap_dfr_pkg::*;

    logic     item_valid;
    in_item_t item;
    logic     can_load;
    logic     step_en;
    result_t  result;

    assign step_en = item_valid && can_load;

    coap_dfr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .advance    (step_en),
        .item_valid (item_valid),
        .item       (item)
    );

    coap_dfr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item),
        .result  (result)
    );

    coap_dfr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_en),
        .result_in (result),
        .can_load  (can_load),
        .elem_ch   (elem_ch)
    );

endmodule
